/* hw/rtl/tcpu_pkg.sv */
// Shared types, operation codes and constants for the toy CPU execute unit.
package tcpu_pkg;

    localparam int REG_COUNT_DEF   = 16;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam int ADDR_W    = 32;
    localparam int OP_W      = 4;
    localparam int IDX_W     = 4;
    localparam int IDX_COUNT = 16;
    localparam int VALUE_W   = 32;

    localparam logic [ADDR_W-1:0] PC_STEP = 32'h4;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_AND  = 4'd0;
    localparam op_t OP_EOR  = 4'd1;
    localparam op_t OP_SUB  = 4'd2;
    localparam op_t OP_RSB  = 4'd3;
    localparam op_t OP_ADD  = 4'd4;
    localparam op_t OP_XCHG = 4'd5;
    localparam op_t OP_MOV  = 4'd6;
    localparam op_t OP_MVN  = 4'd7;
    localparam op_t OP_MULL = 4'd8;
    localparam op_t OP_END  = 4'd9;
    localparam op_t OP_JMP  = 4'd10;
    localparam op_t OP_CMP  = 4'd11;
    localparam op_t OP_JE   = 4'd12;
    localparam op_t OP_JNE  = 4'd13;
    localparam op_t OP_CALL = 4'd14;
    localparam op_t OP_RET  = 4'd15;

    typedef struct packed {
        op_t  op;
        logic use_imm;
    } alu_ctrl_t;

endpackage

/* hw/rtl/tcpu_alu.sv */
// Data path of the execute unit: register result value and write enable per operation.
module tcpu_alu
    import tcpu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  alu_ctrl_t             ctrl,
    input  logic [DATA_WIDTH-1:0] ra,
    input  logic [DATA_WIDTH-1:0] rb,
    input  logic [DATA_WIDTH-1:0] immv,
    output logic                  we,
    output logic [DATA_WIDTH-1:0] wv
);

    logic [DATA_WIDTH-1:0] mov_src;

    assign mov_src = ctrl.use_imm ? immv : rb;

    always_comb
    begin
        we = 1'b1;
        wv = '0;
        case (ctrl.op)
            OP_AND:  wv = ra & rb;
            OP_EOR:  wv = ra ^ rb;
            OP_SUB:  wv = ra - rb;
            OP_RSB:  wv = rb - ra;
            OP_ADD:  wv = ra + rb;
            OP_XCHG: wv = rb;
            OP_MOV:  wv = mov_src;
            OP_MVN:  wv = ~mov_src;
            OP_MULL: wv = ra * rb;
            default:
            begin
                we = 1'b0;
                wv = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/toy_cpu_execute_unit_top.sv */
// Top level of the toy CPU execute unit: input stage, state, stack and result stage.
// One instruction enters per transaction and one result leaves per transaction. An instruction
// is held in the input register, where its source registers are already read, and is executed
// in the cycle it moves to the result register; the unit sustains one instruction per cycle as
// long as results are taken. Register-file reads are captured at input acceptance with bypass
// of the write made at the same edge, and the top of the return stack is kept in a registered
// read of the stack memory, so a call or return followed at once by another still runs at full
// rate. Registers, program counter, compare flag and stack pointer clear at reset and the run
// flag sets; the return-stack memory itself is not cleared and needs no clearing pass.
module toy_cpu_execute_unit_top
    import tcpu_pkg::*;
#(
    parameter int REG_COUNT   = REG_COUNT_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [OP_W-1:0]           operation,
    input  logic [IDX_W-1:0]          dest_index,
    input  logic [IDX_W-1:0]          first_index,
    input  logic [IDX_W-1:0]          second_index,
    input  logic                      use_immediate,
    input  logic signed [VALUE_W-1:0] immediate_value,
    input  logic [ADDR_W-1:0]         target_address,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ADDR_W-1:0]         next_address,
    output logic                      running,
    output logic                      compare_flag,
    output logic                      write_enable,
    output logic signed [VALUE_W-1:0] write_value,
    output logic                      stack_fault
);

    localparam int RIDX_W  = $clog2(REG_COUNT);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int SADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int WIDE_W  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    logic [RIDX_W-1:0] sel_lut [IDX_COUNT];

    for (genvar i = 0; i < IDX_COUNT; i++)
    begin : g_sel
        assign sel_lut[i] = RIDX_W'(i % REG_COUNT);
    end

    logic                  in_valid_reg;
    op_t                   op_reg;
    logic [RIDX_W-1:0]     d_reg;
    logic [RIDX_W-1:0]     a_reg;
    logic [RIDX_W-1:0]     b_reg;
    logic                  use_imm_reg;
    logic [DATA_WIDTH-1:0] imm_reg;
    logic [ADDR_W-1:0]     target_reg;
    logic [DATA_WIDTH-1:0] ra_reg;
    logic [DATA_WIDTH-1:0] rb_reg;

    logic                  out_valid_reg;
    logic [ADDR_W-1:0]     next_address_reg;
    logic                  running_reg;
    logic                  compare_reg;
    logic                  write_enable_reg;
    logic [VALUE_W-1:0]    write_value_reg;
    logic                  fault_reg;

    logic [DATA_WIDTH-1:0] rf_reg [REG_COUNT];
    logic [ADDR_W-1:0]     pc_reg;
    logic                  eq_reg;
    logic                  run_reg;
    logic [SP_W-1:0]       sp_reg;
    logic [ADDR_W-1:0]     tos_reg;
    logic [ADDR_W-1:0]     stack_mem [STACK_DEPTH];

    logic                  advance;
    logic                  in_fire;
    logic [ADDR_W-1:0]     seq;
    logic                  stack_full;
    logic                  stack_empty;
    alu_ctrl_t             alu_ctrl;
    logic                  alu_we;
    logic [DATA_WIDTH-1:0] alu_wv;
    logic [WIDE_W-1:0]     alu_wide;

    logic [ADDR_W-1:0]     pc_next;
    logic                  eq_next;
    logic                  run_next;
    logic                  fault;
    logic                  push;
    logic                  pop;
    logic                  push_en;
    logic                  pop_en;
    logic [SP_W-1:0]       sp_next;
    logic [SP_W-1:0]       sp_top;

    logic                  wr0_en;
    logic [RIDX_W-1:0]     wr0_addr;
    logic                  wr1_en;
    logic [RIDX_W-1:0]     wr1_addr;
    logic [RIDX_W-1:0]     rd_a_addr;
    logic [RIDX_W-1:0]     rd_b_addr;
    logic [DATA_WIDTH-1:0] ra_next;
    logic [DATA_WIDTH-1:0] rb_next;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign seq         = pc_reg + PC_STEP;
    assign stack_full  = (sp_reg == SP_W'(STACK_DEPTH));
    assign stack_empty = (sp_reg == '0);

    assign alu_ctrl.op      = op_reg;
    assign alu_ctrl.use_imm = use_imm_reg;

    tcpu_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .ctrl (alu_ctrl),
        .ra   (ra_reg),
        .rb   (rb_reg),
        .immv (imm_reg),
        .we   (alu_we),
        .wv   (alu_wv)
    );

    assign alu_wide = WIDE_W'(alu_wv);

    always_comb
    begin
        pc_next  = seq;
        eq_next  = eq_reg;
        run_next = run_reg;
        fault    = 1'b0;
        push     = 1'b0;
        pop      = 1'b0;
        case (op_reg)
            OP_END:  run_next = 1'b0;
            OP_JMP:  pc_next = target_reg;
            OP_CMP:  eq_next = (ra_reg == rb_reg);
            OP_JE:
            begin
                if (eq_reg)
                begin
                    pc_next = target_reg;
                end
            end
            OP_JNE:
            begin
                if (!eq_reg)
                begin
                    pc_next = target_reg;
                end
            end
            OP_CALL:
            begin
                if (stack_full)
                begin
                    fault   = 1'b1;
                    pc_next = pc_reg;
                end
                else
                begin
                    push    = 1'b1;
                    pc_next = target_reg;
                end
            end
            OP_RET:
            begin
                if (stack_empty)
                begin
                    fault   = 1'b1;
                    pc_next = pc_reg;
                end
                else
                begin
                    pop     = 1'b1;
                    pc_next = tos_reg;
                end
            end
            default: ;
        endcase
    end

    assign push_en = advance && push;
    assign pop_en  = advance && pop;
    assign sp_next = push_en ? sp_reg + 1'b1 : (pop_en ? sp_reg - 1'b1 : sp_reg);
    assign sp_top  = sp_next - 1'b1;

    assign wr0_en   = advance && alu_we && !((op_reg == OP_XCHG) && (a_reg == b_reg));
    assign wr0_addr = (op_reg == OP_XCHG) ? a_reg : d_reg;
    assign wr1_en   = advance && (op_reg == OP_XCHG);
    assign wr1_addr = b_reg;

    assign rd_a_addr = sel_lut[first_index];
    assign rd_b_addr = sel_lut[second_index];

    always_comb
    begin
        ra_next = rf_reg[rd_a_addr];
        if (wr0_en && (wr0_addr == rd_a_addr))
        begin
            ra_next = alu_wv;
        end
        if (wr1_en && (wr1_addr == rd_a_addr))
        begin
            ra_next = ra_reg;
        end
        rb_next = rf_reg[rd_b_addr];
        if (wr0_en && (wr0_addr == rd_b_addr))
        begin
            rb_next = alu_wv;
        end
        if (wr1_en && (wr1_addr == rd_b_addr))
        begin
            rb_next = ra_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr0_en)
            begin
                rf_reg[wr0_addr] <= alu_wv;
            end
            if (wr1_en)
            begin
                rf_reg[wr1_addr] <= ra_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[sp_reg[SADDR_W-1:0]] <= seq;
        end
        if (push_en)
        begin
            tos_reg <= seq;
        end
        else
        begin
            tos_reg <= stack_mem[sp_top[SADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            eq_reg        <= 1'b0;
            run_reg       <= 1'b1;
            sp_reg        <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pc_reg        <= pc_next;
                eq_reg        <= eq_next;
                run_reg       <= run_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg      <= operation;
            d_reg       <= sel_lut[dest_index];
            a_reg       <= rd_a_addr;
            b_reg       <= rd_b_addr;
            use_imm_reg <= use_immediate;
            imm_reg     <= DATA_WIDTH'(immediate_value);
            target_reg  <= target_address;
            ra_reg      <= ra_next;
            rb_reg      <= rb_next;
        end
        if (advance)
        begin
            next_address_reg <= pc_next;
            running_reg      <= run_next;
            compare_reg      <= eq_next;
            write_enable_reg <= alu_we;
            write_value_reg  <= alu_we ? alu_wide[VALUE_W-1:0] : '0;
            fault_reg        <= fault;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_address = next_address_reg;
    assign running      = running_reg;
    assign compare_flag = compare_reg;
    assign write_enable = write_enable_reg;
    assign write_value  = write_value_reg;
    assign stack_fault  = fault_reg;

    a_fault_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        advance && fault |=> pc_reg == $past(pc_reg))
        else $error("stack fault moved the program counter");

    a_call_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg == OP_CALL) && !stack_full |=> sp_reg == $past(sp_reg) + 1'b1)
        else $error("call did not push the return stack");

    a_ret_pops_top: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg == OP_RET) && !stack_empty |=> pc_reg == $past(tos_reg))
        else $error("return did not jump to the top of the stack");

    a_run_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |=> !run_reg)
        else $error("run flag came back after end");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !write_enable_reg |-> write_value_reg == '0)
        else $error("write value not zero without a register write");

endmodule

/* tb/tb_toy_cpu_execute_unit_top.sv */
// Self-checking testbench for the toy CPU execute unit: directed and random instruction streams.
`timescale 1ns / 1ps

module tb_toy_cpu_execute_unit_top;
    import tcpu_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_COUNT = 1180;
    localparam int STACK_SLOTS  = STACK_DEPTH_DEF;

    typedef struct {
        op_t                      op;
        logic [IDX_W-1:0]         dest;
        logic [IDX_W-1:0]         first;
        logic [IDX_W-1:0]         second;
        logic                     use_imm;
        logic signed [VALUE_W-1:0] imm;
        logic [ADDR_W-1:0]        target;
    } instr_t;

    typedef struct {
        logic [ADDR_W-1:0]         next_address;
        logic                      running;
        logic                      compare_flag;
        logic                      write_enable;
        logic signed [VALUE_W-1:0] write_value;
        logic                      stack_fault;
    } outcome_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [OP_W-1:0]           operation;
    logic [IDX_W-1:0]          dest_index;
    logic [IDX_W-1:0]          first_index;
    logic [IDX_W-1:0]          second_index;
    logic                      use_immediate;
    logic signed [VALUE_W-1:0] immediate_value;
    logic [ADDR_W-1:0]         target_address;
    logic                      out_valid;
    logic                      out_ready;
    logic [ADDR_W-1:0]         next_address;
    logic                      running;
    logic                      compare_flag;
    logic                      write_enable;
    logic signed [VALUE_W-1:0] write_value;
    logic                      stack_fault;

    logic [VALUE_W-1:0] gpr [IDX_COUNT];
    logic [ADDR_W-1:0]  ret_stack [STACK_SLOTS];
    logic [ADDR_W-1:0]  pc;
    logic               eq_flag;
    logic               run_flag;
    int                 ret_depth;

    outcome_t expected_outcomes [$];
    int       fail_count;
    int       cycle_count;
    bit       send_throttle;
    bit       recv_throttle;
    int       stall_request;
    int       hold_left;
    int       gap_left;

    toy_cpu_execute_unit_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .dest_index      (dest_index),
        .first_index     (first_index),
        .second_index    (second_index),
        .use_immediate   (use_immediate),
        .immediate_value (immediate_value),
        .target_address  (target_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .next_address    (next_address),
        .running         (running),
        .compare_flag    (compare_flag),
        .write_enable    (write_enable),
        .write_value     (write_value),
        .stack_fault     (stack_fault)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic instr_t make_instr(op_t op, int d, int a, int b, bit imm_flag,
                                          logic [31:0] imm, logic [31:0] target);
        instr_t ins;
        ins.op      = op;
        ins.dest    = d[IDX_W-1:0];
        ins.first   = a[IDX_W-1:0];
        ins.second  = b[IDX_W-1:0];
        ins.use_imm = imm_flag;
        ins.imm     = imm;
        ins.target  = target;
        return ins;
    endfunction

    function automatic void reset_cpu_state();
        foreach (gpr[i])
            gpr[i] = '0;
        pc        = '0;
        eq_flag   = 1'b0;
        run_flag  = 1'b1;
        ret_depth = 0;
    endfunction

    function automatic outcome_t execute_instr(instr_t ins);
        outcome_t           res;
        logic [VALUE_W-1:0] ra;
        logic [VALUE_W-1:0] rb;
        logic [VALUE_W-1:0] operand;
        logic [ADDR_W-1:0]  seq_pc;
        ra      = gpr[ins.first];
        rb      = gpr[ins.second];
        operand = ins.use_imm ? ins.imm : rb;
        seq_pc  = pc + PC_STEP;
        res.next_address = seq_pc;
        res.write_enable = 1'b0;
        res.write_value  = '0;
        res.stack_fault  = 1'b0;
        case (ins.op)
            OP_AND:  res.write_value = ra & rb;
            OP_EOR:  res.write_value = ra ^ rb;
            OP_SUB:  res.write_value = ra - rb;
            OP_RSB:  res.write_value = rb - ra;
            OP_ADD:  res.write_value = ra + rb;
            OP_XCHG:
            begin
                gpr[ins.first]  = rb;
                gpr[ins.second] = ra;
                res.write_value = rb;
            end
            OP_MOV:  res.write_value = operand;
            OP_MVN:  res.write_value = ~operand;
            OP_MULL: res.write_value = ra * rb;
            OP_END:  run_flag = 1'b0;
            OP_JMP:  res.next_address = ins.target;
            OP_CMP:  eq_flag = (ra == rb);
            OP_JE:   res.next_address = eq_flag ? ins.target : seq_pc;
            OP_JNE:  res.next_address = eq_flag ? seq_pc : ins.target;
            OP_CALL:
            begin
                if (ret_depth >= STACK_SLOTS)
                begin
                    res.stack_fault  = 1'b1;
                    res.next_address = pc;
                end
                else
                begin
                    ret_stack[ret_depth] = seq_pc;
                    ret_depth++;
                    res.next_address = ins.target;
                end
            end
            default:
            begin
                if (ret_depth == 0)
                begin
                    res.stack_fault  = 1'b1;
                    res.next_address = pc;
                end
                else
                begin
                    ret_depth--;
                    res.next_address = ret_stack[ret_depth];
                end
            end
        endcase
        if (ins.op <= OP_MULL)
        begin
            res.write_enable = 1'b1;
            if (ins.op != OP_XCHG)
                gpr[ins.dest] = res.write_value;
        end
        pc = res.next_address;
        res.running      = run_flag;
        res.compare_flag = eq_flag;
        return res;
    endfunction

    function automatic instr_t random_instr();
        instr_t ins;
        int     op_pick;
        op_pick = $urandom_range(0, 14);
        if (op_pick >= OP_END)
            op_pick++;
        ins.op      = op_t'(op_pick);
        ins.dest    = 4'($urandom_range(0, 15));
        ins.first   = 4'($urandom_range(0, 15));
        ins.second  = ($urandom_range(0, 3) == 0) ? ins.first : 4'($urandom_range(0, 15));
        ins.use_imm = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       ins.imm = 32'h8000_0000;
            1:       ins.imm = 32'h7FFF_FFFF;
            2:       ins.imm = 32'hFFFF_FFFF;
            3:       ins.imm = $urandom_range(0, 3);
            default: ins.imm = $urandom();
        endcase
        ins.target  = $urandom();
        return ins;
    endfunction

    task automatic send_instr(instr_t ins);
        int gap;
        gap = send_throttle ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        operation       <= ins.op;
        dest_index      <= ins.dest;
        first_index     <= ins.first;
        second_index    <= ins.second;
        use_immediate   <= ins.use_imm;
        immediate_value <= ins.imm;
        target_address  <= ins.target;
        do
            @(posedge clk);
        while (!in_ready);
        expected_outcomes.push_back(execute_instr(ins));
    endtask

    always @(posedge clk)
    begin : result_check
        outcome_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("result transaction with no instruction pending");
                fail_count++;
            end
            else
            begin
                exp = expected_outcomes.pop_front();
                if (next_address !== exp.next_address)
                begin
                    $error("next_address: expected %h, got %h", exp.next_address, next_address);
                    fail_count++;
                end
                if (running !== exp.running)
                begin
                    $error("running: expected %b, got %b", exp.running, running);
                    fail_count++;
                end
                if (compare_flag !== exp.compare_flag)
                begin
                    $error("compare_flag: expected %b, got %b", exp.compare_flag, compare_flag);
                    fail_count++;
                end
                if (write_enable !== exp.write_enable)
                begin
                    $error("write_enable: expected %b, got %b", exp.write_enable, write_enable);
                    fail_count++;
                end
                if (write_value !== exp.write_value)
                begin
                    $error("write_value: expected %h, got %h", exp.write_value, write_value);
                    fail_count++;
                end
                if (stack_fault !== exp.stack_fault)
                begin
                    $error("stack_fault: expected %b, got %b", exp.stack_fault, stack_fault);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        out_ready <= 1'b0;
        hold_left = 0;
        gap_left  = 0;
        forever
        begin
            @(posedge clk);
            if (stall_request > 0)
            begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                out_ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (recv_throttle && $urandom_range(0, 2) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic test_data_ops();
        send_instr(make_instr(OP_MOV, 1, 0, 0, 1, 32'h7FFF_FFFF, '0));
        send_instr(make_instr(OP_MOV, 2, 0, 0, 1, 32'h8000_0000, '0));
        send_instr(make_instr(OP_MVN, 3, 0, 0, 1, 32'hFFFF_FFFF, '0));
        send_instr(make_instr(OP_MVN, 4, 0, 2, 0, '0, '0));
        send_instr(make_instr(OP_ADD, 5, 1, 2, 0, '0, '0));
        send_instr(make_instr(OP_ADD, 6, 1, 1, 0, '0, '0));
        send_instr(make_instr(OP_SUB, 7, 2, 1, 0, '0, '0));
        send_instr(make_instr(OP_RSB, 8, 2, 1, 0, '0, '0));
        send_instr(make_instr(OP_AND, 9, 5, 1, 0, '0, '0));
        send_instr(make_instr(OP_EOR, 10, 5, 2, 0, '0, '0));
        send_instr(make_instr(OP_MULL, 11, 5, 5, 0, '0, '0));
        send_instr(make_instr(OP_MULL, 12, 1, 2, 0, '0, '0));
        send_instr(make_instr(OP_XCHG, 15, 1, 2, 1, 32'hFFFF_FFFF, '1));
        send_instr(make_instr(OP_XCHG, 0, 3, 3, 0, '0, '0));
        send_instr(make_instr(OP_MOV, 13, 0, 2, 0, 32'h1234_5678, '0));
        send_instr(make_instr(OP_ADD, 15, 15, 15, 0, '0, '0));
    endtask

    task automatic test_control_flow();
        send_instr(make_instr(OP_CMP, 0, 1, 4, 0, '0, '0));
        send_instr(make_instr(OP_JE, 0, 0, 0, 0, '0, 32'h0000_1000));
        send_instr(make_instr(OP_JNE, 0, 0, 0, 0, '0, 32'h0000_1000));
        send_instr(make_instr(OP_CMP, 0, 4, 4, 0, '0, '0));
        send_instr(make_instr(OP_JE, 0, 0, 0, 0, '0, 32'hFFFF_FFFC));
        send_instr(make_instr(OP_MOV, 14, 0, 0, 1, 32'h0000_0001, '0));
        send_instr(make_instr(OP_JNE, 0, 0, 0, 0, '0, 32'h0000_2000));
        send_instr(make_instr(OP_JMP, 0, 0, 0, 0, '0, 32'hFFFF_FFFC));
        send_instr(make_instr(OP_CALL, 0, 0, 0, 0, '0, 32'h0000_0040));
        send_instr(make_instr(OP_CALL, 0, 0, 0, 0, '0, 32'h0000_0000));
        send_instr(make_instr(OP_RET, 0, 0, 0, 0, '0, '0));
        send_instr(make_instr(OP_RET, 0, 0, 0, 0, '0, '0));
        send_instr(make_instr(OP_RET, 0, 0, 0, 0, '0, 32'h0000_0080));
    endtask

    task automatic test_stack_limits();
        repeat (STACK_SLOTS + 2)
            send_instr(make_instr(OP_CALL, 0, 0, 0, 0, '0, $urandom()));
        send_instr(make_instr(OP_MOV, 1, 0, 0, 1, 32'h0000_0005, '0));
        repeat (STACK_SLOTS + 2)
            send_instr(make_instr(OP_RET, 0, 0, 0, 0, '0, $urandom()));
    endtask

    task automatic test_backpressure();
        send_throttle = 1'b0;
        recv_throttle = 1'b0;
        stall_request = 150;
        repeat (40)
            send_instr(random_instr());
    endtask

    task automatic test_random_stream();
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i % 100 == 0)
            begin
                send_throttle = ($urandom_range(0, 3) != 0);
                recv_throttle = ($urandom_range(0, 3) != 0);
            end
            send_instr(random_instr());
        end
    endtask

    task automatic test_end_instruction();
        send_throttle = 1'b1;
        recv_throttle = 1'b1;
        send_instr(make_instr(OP_END, 0, 0, 0, 0, '0, '0));
        repeat (12)
            send_instr(random_instr());
        send_instr(make_instr(OP_END, 3, 4, 5, 1, '1, '1));
        send_instr(make_instr(OP_ADD, 1, 2, 3, 0, '0, '0));
    endtask

    initial
    begin
        fail_count    = 0;
        stall_request = 0;
        send_throttle = 1'b1;
        recv_throttle = 1'b1;
        reset_cpu_state();
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        operation       <= OP_AND;
        dest_index      <= '0;
        first_index     <= '0;
        second_index    <= '0;
        use_immediate   <= 1'b0;
        immediate_value <= '0;
        target_address  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_data_ops();
        test_control_flow();
        test_stack_limits();
        test_backpressure();
        test_random_stream();
        test_end_instruction();

        in_valid <= 1'b0;
        wait (expected_outcomes.size() == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
